// ----- design/lqwh_pkg.sv -----
// Shared types and constants for the link quality window block.
`timescale 1ns / 1ps
package lqwh_pkg;

  localparam int Q_W = 24;
  localparam int THR_W = 24;
  localparam int WLEN_W = 5;
  localparam int MARGIN_W = 23;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int MET_SUM_W = 26;

  localparam logic signed [Q_W-1:0] Q_MAX = 24'sh7FFFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 24'sh800000;

  localparam logic signed [THR_W-1:0] THR_RST = 24'sd1280;
  localparam logic [WLEN_W-1:0] WLEN_RST = 5'd10;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 23'd768;
  localparam logic signed [Q_W-1:0] STRENGTH_RST = 24'sd25600;

  // ceil(2^26 / 3): exact truncating divide by three for magnitudes below 2^25
  localparam int RECIP3_W = 25;
  localparam int RECIP3_SHIFT = 26;
  localparam logic [RECIP3_W-1:0] RECIP3 = 25'd22369622;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WINDOW = 2'd1;
  localparam logic [1:0] REG_MARGIN = 2'd2;

  localparam logic [1:0] FN_STRENGTH = 2'd0;
  localparam logic [1:0] FN_BANDWIDTH = 2'd1;
  localparam logic [1:0] FN_DELAY = 2'd2;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_ON = 2'd1;
  localparam logic [1:0] ACT_OFF = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_RAW_GO,
    S_RAW_WAIT,
    S_PUSH,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_FIN
  } lqwh_state_t;

  typedef struct packed {
    logic load;
    logic upd;
    logic raw_go;
    logic raw_cap;
    logic push;
    logic mean_go;
    logic mean_cap;
    logic fin;
  } lqwh_cmd_t;

  typedef struct packed {
    logic bad_peer;
    logic div_done;
    logic out_busy;
  } lqwh_sts_t;

endpackage

// ----- design/lqwh_regs.sv -----
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
module lqwh_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lqwh_pkg::ADDR_W-1:0]   paddr,
  input  logic [lqwh_pkg::DATA_W-1:0]   pwdata,
  output logic [lqwh_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic signed [lqwh_pkg::THR_W-1:0] thr,
  output logic [lqwh_pkg::WLEN_W-1:0]   wlen,
  output logic [lqwh_pkg::MARGIN_W-1:0] margin,
  output logic                          clr_hist
);
  import lqwh_pkg::*;

  logic signed [THR_W-1:0] thr_r;
  logic [WLEN_W-1:0] wlen_r;
  logic [MARGIN_W-1:0] margin_r;
  logic [1:0] idx;
  logic wr;

  assign idx = paddr[3:2];
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RST;
      wlen_r <= WLEN_RST;
      margin_r <= MARGIN_RST;
    end else if (wr) begin
      case (idx)
        REG_THRESHOLD: thr_r <= pwdata[THR_W-1:0];
        REG_WINDOW: wlen_r <= pwdata[WLEN_W-1:0];
        REG_MARGIN: margin_r <= pwdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // a changed window length drops all history
  assign clr_hist = wr && (idx == REG_WINDOW) && (pwdata[WLEN_W-1:0] != wlen_r);

  always_comb begin
    case (idx)
      REG_THRESHOLD: prdata = DATA_W'(unsigned'(thr_r));
      REG_WINDOW: prdata = DATA_W'(wlen_r);
      REG_MARGIN: prdata = DATA_W'(margin_r);
      default: prdata = '0;
    endcase
  end

  assign thr = thr_r;
  assign wlen = wlen_r;
  assign margin = margin_r;
endmodule

// ----- design/lqwh_div.sv -----
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
`timescale 1ns / 1ps
module lqwh_div #(
  parameter int DVD_W = 29,
  parameter int DVS_W = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0]        divisor,
  output logic signed [DVD_W-1:0] quotient,
  output logic                    done
);
  localparam int CW = $clog2(DVD_W + 1);

  logic busy_r, done_r, neg_r;
  logic [CW-1:0] cnt_r;
  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r, d_r;
  logic [DVS_W:0] rs;
  logic fit;

  assign rs = {rem_r, q_r[DVD_W-1]};
  assign fit = rs >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= CW'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend[DVD_W-1] ? unsigned'(-dividend) : unsigned'(dividend);
      rem_r <= '0;
      d_r <= divisor;
      neg_r <= dividend[DVD_W-1];
    end else if (busy_r) begin
      rem_r <= fit ? DVS_W'(rs - {1'b0, d_r}) : rs[DVS_W-1:0];
      q_r <= {q_r[DVD_W-2:0], fit};
    end
  end

  assign quotient = neg_r ? -signed'(q_r) : signed'(q_r);
  assign done = done_r;
endmodule

// ----- design/lqwh_ctrl.sv -----
// Sequencer for one item: metric update, raw divide, window push, mean divide, result.
`timescale 1ns / 1ps
module lqwh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lqwh_pkg::lqwh_sts_t sts,
  output lqwh_pkg::lqwh_cmd_t cmd
);
  import lqwh_pkg::*;

  lqwh_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_UPD;
      S_UPD: state_nxt = sts.bad_peer ? S_FIN : S_RAW_GO;
      S_RAW_GO: state_nxt = S_RAW_WAIT;
      S_RAW_WAIT: state_nxt = S_PUSH;
      S_PUSH: state_nxt = S_MEAN_GO;
      S_MEAN_GO: state_nxt = S_MEAN_WAIT;
      S_MEAN_WAIT: if (sts.div_done) state_nxt = S_FIN;
      S_FIN: if (!sts.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_UPD: cmd.upd = 1'b1;
      S_RAW_GO: cmd.raw_go = 1'b1;
      S_RAW_WAIT: cmd.raw_cap = 1'b1;
      S_PUSH: cmd.push = 1'b1;
      S_MEAN_GO: cmd.mean_go = 1'b1;
      S_MEAN_WAIT: cmd.mean_cap = 1'b1;
      S_FIN: cmd.fin = 1'b1;
      default: ;
    endcase
  end
endmodule

// ----- design/lqwh_dp.sv -----
// Datapath: per-peer metrics, history ring, window sums, hysteresis and result register.
`timescale 1ns / 1ps
module lqwh_dp #(
  parameter int NUM_PEERS = 4,
  parameter int WINDOW_MAX = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lqwh_pkg::lqwh_cmd_t               cmd,
  output lqwh_pkg::lqwh_sts_t               sts,
  input  logic [1:0]                        in_peer,
  input  logic [1:0]                        in_func,
  input  logic signed [lqwh_pkg::Q_W-1:0]   in_metric_value,
  input  logic signed [lqwh_pkg::THR_W-1:0] thr,
  input  logic [lqwh_pkg::WLEN_W-1:0]       wlen,
  input  logic [lqwh_pkg::MARGIN_W-1:0]     margin,
  input  logic                              clr_hist,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_peer_out,
  output logic signed [lqwh_pkg::Q_W-1:0]   out_mean_quality,
  output logic                              out_full_map_on,
  output logic [1:0]                        out_action,
  output logic                              out_forward_full
);
  import lqwh_pkg::*;

  localparam int LW = $clog2(WINDOW_MAX + 1);
  localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int PIW = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
  localparam int DEPTH = NUM_PEERS * WINDOW_MAX;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = Q_W + LW;
  localparam int DVD_W = SUM_W;
  localparam int DVS_W = LW;
  localparam int HW = Q_W + 2;
  localparam int PROD_W = MET_SUM_W + RECIP3_W;

  logic [1:0] peer_r, func_r;
  logic signed [Q_W-1:0] val_r;
  logic [PIW-1:0] pidx;
  logic bad;

  logic signed [Q_W-1:0] str_r [NUM_PEERS];
  logic signed [Q_W-1:0] bw_r [NUM_PEERS];
  logic signed [Q_W-1:0] dly_r [NUM_PEERS];
  logic [LW-1:0] fill_r [NUM_PEERS];
  logic [PW-1:0] ptr_r [NUM_PEERS];
  logic signed [SUM_W-1:0] sum_r [NUM_PEERS];
  logic flag_r [NUM_PEERS];

  logic signed [Q_W-1:0] ring [DEPTH];
  logic signed [Q_W-1:0] ring_rd_r;
  logic [AW-1:0] ring_addr;

  logic [LW-1:0] len_eff;
  logic [PW-1:0] ptr_eff, ptr_q_r, ptr_inc;
  logic signed [Q_W-1:0] s_new, b_new, d_new;
  logic signed [MET_SUM_W-1:0] sum3_r;
  logic signed [Q_W-1:0] raw_r, mean_r;
  logic signed [SUM_W-1:0] sum_new;

  logic [MET_SUM_W-1:0] mag3, q3_mag;
  logic [PROD_W-1:0] prod3_r;
  logic neg3_r;
  logic signed [MET_SUM_W-1:0] quo3;

  logic div_start;
  logic signed [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs;
  logic div_done;

  logic signed [HW-1:0] mean_x, thr_x, on_lvl, off_lvl;
  logic flag_nxt;
  logic [1:0] act;

  logic out_valid_r, full_r, fwd_r;
  logic [1:0] peer_out_r, act_r;
  logic signed [Q_W-1:0] mq_r;

  assign pidx = PIW'(peer_r);
  assign bad = 32'(peer_r) >= NUM_PEERS;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      peer_r <= in_peer;
      func_r <= in_func;
      val_r <= in_metric_value;
    end
  end

  always_comb begin
    if (wlen == '0) len_eff = LW'(1);
    else if (32'(wlen) > WINDOW_MAX) len_eff = LW'(WINDOW_MAX);
    else len_eff = LW'(wlen);
  end

  assign ptr_eff = (32'(ptr_r[pidx]) >= 32'(len_eff)) ? '0 : ptr_r[pidx];
  assign ptr_inc = PW'(32'(ptr_q_r) + 1);
  assign ring_addr = AW'(32'(pidx) * WINDOW_MAX + 32'(cmd.upd ? ptr_eff : ptr_q_r));

  assign s_new = (func_r == FN_STRENGTH) ? val_r : str_r[pidx];
  assign b_new = (func_r == FN_BANDWIDTH) ? val_r : bw_r[pidx];
  assign d_new = (func_r == FN_DELAY) ? val_r : dly_r[pidx];

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      sum3_r <= MET_SUM_W'(s_new) + MET_SUM_W'(b_new) - MET_SUM_W'(d_new);
      ptr_q_r <= ptr_eff;
      ring_rd_r <= ring[ring_addr];
    end
    if (cmd.push && !bad) ring[ring_addr] <= raw_r;
  end

  // divide by three: multiply the magnitude by the reciprocal, restore the sign
  assign mag3 = sum3_r[MET_SUM_W-1] ? unsigned'(-sum3_r) : unsigned'(sum3_r);
  assign q3_mag = MET_SUM_W'(prod3_r[PROD_W-1:RECIP3_SHIFT]);
  assign quo3 = neg3_r ? -signed'(q3_mag) : signed'(q3_mag);

  always_ff @(posedge clk) begin
    if (cmd.raw_go) begin
      prod3_r <= PROD_W'(mag3) * PROD_W'(RECIP3);
      neg3_r <= sum3_r[MET_SUM_W-1];
    end
    if (cmd.raw_cap) begin
      if (quo3 > MET_SUM_W'(Q_MAX)) raw_r <= Q_MAX;
      else if (quo3 < MET_SUM_W'(Q_MIN)) raw_r <= Q_MIN;
      else raw_r <= quo3[Q_W-1:0];
    end
    if (cmd.mean_cap && div_done) mean_r <= div_q[Q_W-1:0];
  end

  always_comb begin
    if (fill_r[pidx] < len_eff) sum_new = sum_r[pidx] + SUM_W'(raw_r);
    else sum_new = sum_r[pidx] - SUM_W'(ring_rd_r) + SUM_W'(raw_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PEERS; i++) begin
        str_r[i] <= STRENGTH_RST;
        bw_r[i] <= '0;
        dly_r[i] <= '0;
        fill_r[i] <= '0;
        ptr_r[i] <= '0;
        sum_r[i] <= '0;
        flag_r[i] <= 1'b0;
      end
    end else if (clr_hist) begin
      for (int i = 0; i < NUM_PEERS; i++) begin
        fill_r[i] <= '0;
        ptr_r[i] <= '0;
        sum_r[i] <= '0;
      end
    end else if (!bad) begin
      if (cmd.upd) begin
        case (func_r)
          FN_STRENGTH: str_r[pidx] <= val_r;
          FN_BANDWIDTH: bw_r[pidx] <= val_r;
          FN_DELAY: dly_r[pidx] <= val_r;
          default: ;
        endcase
      end
      if (cmd.push) begin
        if (fill_r[pidx] < len_eff) fill_r[pidx] <= fill_r[pidx] + 1'b1;
        sum_r[pidx] <= sum_new;
        ptr_r[pidx] <= (32'(ptr_inc) >= 32'(len_eff)) ? '0 : ptr_inc;
      end
      if (cmd.fin && !sts.out_busy) flag_r[pidx] <= flag_nxt;
    end
  end

  // the divider computes the mean of the window
  assign div_start = cmd.mean_go;
  assign div_dvd = DVD_W'(sum_r[pidx]);
  assign div_dvs = DVS_W'(fill_r[pidx]);

  lqwh_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk(clk),
    .rst_n(rst_n),
    .start(div_start),
    .dividend(div_dvd),
    .divisor(div_dvs),
    .quotient(div_q),
    .done(div_done)
  );

  assign mean_x = HW'(mean_r);
  assign thr_x = HW'(thr);
  assign on_lvl = thr_x + signed'(HW'(margin));
  assign off_lvl = thr_x - signed'(HW'(margin));

  always_comb begin
    flag_nxt = flag_r[pidx];
    act = ACT_NONE;
    if (mean_x >= on_lvl && !flag_r[pidx]) begin
      flag_nxt = 1'b1;
      act = ACT_ON;
    end else if (mean_x <= off_lvl && flag_r[pidx]) begin
      flag_nxt = 1'b0;
      act = ACT_OFF;
    end
  end

  assign sts.bad_peer = bad;
  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.fin && !sts.out_busy) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin && !sts.out_busy) begin
      peer_out_r <= peer_r;
      if (bad) begin
        mq_r <= '0;
        full_r <= 1'b0;
        act_r <= ACT_NONE;
        fwd_r <= 1'b0;
      end else begin
        mq_r <= mean_r;
        full_r <= flag_nxt;
        act_r <= act;
        fwd_r <= flag_nxt && (mean_x >= thr_x);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_peer_out = peer_out_r;
  assign out_mean_quality = mq_r;
  assign out_full_map_on = full_r;
  assign out_action = act_r;
  assign out_forward_full = fwd_r;
endmodule

// ----- design/link_quality_window_hysteresis.sv -----
// Top level of the per-peer link quality window with hysteresis.
//
// Input channel (in_valid/in_stall): one item sets at most one metric (strength,
// bandwidth or delay) of one peer; each item gives exactly one result item.
// Result channel (out_valid/out_stall): peer, windowed mean, hysteresis flag,
// switch action and forwarding permit.
// Items are handled one at a time. The raw quality is divided by three with a
// registered reciprocal multiply; the window sum is divided by the fill count
// in a one-bit-per-cycle divider whose dividend is DVD_W bits wide, with
// DVD_W = 24+clog2(WINDOW_MAX+1). The result is offered once the mean divide
// is done, and the next item can be taken once the previous result has been
// loaded into the output register. A peer index at or above NUM_PEERS skips
// the arithmetic and offers its peer index with all other fields zero.
// The result sits in an output register and the next item is accepted while
// it waits; if the receiver still stalls when the next result is ready, that
// result is held back and the input stalls until the register frees.
// Reset (rst_n low, synchronous) restores register defaults, clears all window
// history and flags and needs no clearing pass. Configuration is written over
// the APB-style port; the user must write it only while idle, which the block
// does not enforce. A new window length drops the history of every peer.
`timescale 1ns / 1ps
module link_quality_window_hysteresis #(
  parameter int NUM_PEERS = 4,
  parameter int WINDOW_MAX = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_peer,
  input  logic [1:0]                      in_func,
  input  logic signed [lqwh_pkg::Q_W-1:0] in_metric_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_peer_out,
  output logic signed [lqwh_pkg::Q_W-1:0] out_mean_quality,
  output logic                            out_full_map_on,
  output logic [1:0]                      out_action,
  output logic                            out_forward_full,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lqwh_pkg::ADDR_W-1:0]     paddr,
  input  logic [lqwh_pkg::DATA_W-1:0]     pwdata,
  output logic [lqwh_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import lqwh_pkg::*;

  lqwh_cmd_t cmd;
  lqwh_sts_t sts;
  logic signed [THR_W-1:0] thr;
  logic [WLEN_W-1:0] wlen;
  logic [MARGIN_W-1:0] margin;
  logic clr_hist;

  lqwh_regs u_regs (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .thr(thr), .wlen(wlen), .margin(margin), .clr_hist(clr_hist)
  );

  lqwh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  lqwh_dp #(.NUM_PEERS(NUM_PEERS), .WINDOW_MAX(WINDOW_MAX)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cmd(cmd), .sts(sts),
    .in_peer(in_peer), .in_func(in_func), .in_metric_value(in_metric_value),
    .thr(thr), .wlen(wlen), .margin(margin), .clr_hist(clr_hist),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_peer_out(out_peer_out), .out_mean_quality(out_mean_quality),
    .out_full_map_on(out_full_map_on), .out_action(out_action),
    .out_forward_full(out_forward_full)
  );
endmodule

// ----- design/lqwh_checker.sv -----
// Port-level checks for the link quality block, bound to the top level.
`timescale 1ns / 1ps
module lqwh_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_full_map_on,
  input logic [1:0] out_action,
  input logic       out_forward_full
);
  import lqwh_pkg::*;

  // a result waiting on the receiver stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // one item at a time: the cycle after an accept is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken before the first finished");

  a_on_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_ON |-> out_full_map_on)
    else $error("switch-on with flag low");

  a_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_OFF |-> !out_full_map_on && !out_forward_full)
    else $error("switch-off with flag or permit high");

  a_fwd_needs_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_forward_full |-> out_full_map_on)
    else $error("forward permit without flag");
endmodule

bind link_quality_window_hysteresis lqwh_checker u_lqwh_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_full_map_on(out_full_map_on),
  .out_action(out_action),
  .out_forward_full(out_forward_full)
);
